[sv/assert_macros.svh]
// Assertion macros used by the RTL top level of the field evaluator.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PPF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("assertion failed");
`define PPF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("implication failed");
`define PPF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle implication failed");
`else
`define PPF_ASSERT(lbl, clk, rst_n, prop)
`define PPF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PPF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/ppf_pkg.sv]
// Shared types and codes for the potential field evaluator.
// Depends on nothing; used by the cell, the top level and the bench.
`default_nettype none
package ppf_pkg;
	typedef enum logic [1:0] {
		ACT_LOAD_PLANE = 2'd0,
		ACT_LOAD_XFORM = 2'd1,
		ACT_EVAL       = 2'd2,
		ACT_NONE       = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_PLANE_COUNT = 3'd0,
		REG_K_WEIGHT    = 3'd1,
		REG_INV_SMALL   = 3'd2,
		REG_INV_BIG     = 3'd3,
		REG_CLUMP_MODE  = 3'd4
	} reg_index_t;

	localparam int ROT_WORDS   = 9;
	localparam int CENTRE_BASE = 9;
	localparam int XFORM_WORDS = 12;
	localparam logic [16:0] K_ONE = 17'd65536;

	// Partial sum and clip flag handed from one plane cell to the next.
	typedef struct packed {
		logic [63:0] sum;
		logic        sat;
	} ppf_link_t;
endpackage
`default_nettype wire

[sv/ppf_in_if.sv]
// Input channel of the field evaluator: handshake and item fields.
// Depends on nothing.
`default_nettype none
interface ppf_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [3:0]         slot_index;
	logic signed [31:0] word_a;
	logic signed [31:0] word_b;
	logic signed [31:0] word_c;
	logic signed [31:0] word_d;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	modport source (output valid, action, slot_index, word_a, word_b, word_c, word_d,
		point_x, point_y, point_z, input ready);
	modport sink (input valid, action, slot_index, word_a, word_b, word_c, word_d,
		point_x, point_y, point_z, output ready);
endinterface
`default_nettype wire

[sv/ppf_out_if.sv]
// Result channel of the field evaluator: handshake and result fields.
// Depends on nothing.
`default_nettype none
interface ppf_out_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] potential_value;
	logic               saturated;
	modport source (output valid, potential_value, saturated, input ready);
	modport sink (input valid, potential_value, saturated, output ready);
endinterface
`default_nettype wire

[sv/ppf_cell.sv]
// One plane cell: holds a plane, computes its clipped squared distance and
// adds it, when active, to the partial sum from its left neighbor. Depends on ppf_pkg.
`default_nettype none
module ppf_cell
	import ppf_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               load,
	input  wire logic signed [31:0] coef_a,
	input  wire logic signed [31:0] coef_b,
	input  wire logic signed [31:0] coef_c,
	input  wire logic signed [31:0] coef_d,
	input  wire logic signed [31:0] loc_x,
	input  wire logic signed [31:0] loc_y,
	input  wire logic signed [31:0] loc_z,
	input  wire logic               active,
	input  wire ppf_link_t          link_in,
	output ppf_link_t               link_out
);
	logic signed [31:0] a_q, b_q, c_q, d_q;
	logic signed [63:0] pa_s1, pb_s1, pc_s1;
	logic signed [63:0] plane_dist;
	logic [30:0]        t_s2;
	logic               sat_s2;
	logic [63:0]        term_s3;
	logic               sat_s3;
	ppf_link_t          link_q;

	always_ff @(posedge clk) begin
		if (load) begin
			a_q <= coef_a;
			b_q <= coef_b;
			c_q <= coef_c;
			d_q <= coef_d;
		end
	end

	assign plane_dist = pa_s1 + pb_s1 + pc_s1 - 64'(d_q);

	always_ff @(posedge clk) begin
		pa_s1 <= (64'(a_q) * 64'(loc_x)) >>> FRAC_BITS;
		pb_s1 <= (64'(b_q) * 64'(loc_y)) >>> FRAC_BITS;
		pc_s1 <= (64'(c_q) * 64'(loc_z)) >>> FRAC_BITS;
		// Non-positive distances contribute nothing; large ones clip.
		if (plane_dist <= 64'sd0) begin
			t_s2 <= '0;
			sat_s2 <= 1'b0;
		end else if (plane_dist > 64'sh7FFF_FFFF) begin
			t_s2 <= '1;
			sat_s2 <= 1'b1;
		end else begin
			t_s2 <= plane_dist[30:0];
			sat_s2 <= 1'b0;
		end
		term_s3 <= (64'(t_s2) * 64'(t_s2)) >> FRAC_BITS;
		sat_s3 <= sat_s2;
		link_q.sum <= link_in.sum + (active ? term_s3 : 64'd0);
		link_q.sat <= link_in.sat | (active & sat_s3);
	end

	assign link_out = link_q;
endmodule
`default_nettype wire

[sv/potential_particle_field_eval_unit.sv]
// Top level of the potential field evaluator: sequencer, transform, plane
// cell chain, scaling and blend. Depends on ppf_pkg, ppf_in_if, ppf_out_if, ppf_cell.
//
//  channel  | dir | beat
//  ---------+-----+---------------------------------------------------
//  in_ch    | in  | action, slot, plane words a..d, point x,y,z
//  out_ch   | out | potential_value (Q32.16), saturated
//  apb      | in  | register writes and reads, no wait states
//
// A load beat is written in the cycle that accepts it. An evaluate beat passes
// through the transform (rotation products, then local coordinates), the chain of
// plane cells, where the partial sum ripples from cell to cell behind the cell
// pipeline, and scaling and blend. One item is in work at a time; the next beat
// is taken while a finished result waits on out_ch. Reset returns the registers
// to their defaults and the sequencer to idle; table contents need loading.
`default_nettype none
`include "assert_macros.svh"
module potential_particle_field_eval_unit
	import ppf_pkg::*;
#(
	parameter int MAX_PLANES = 16,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ppf_in_if.sink           in_ch,
	ppf_out_if.source        out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	localparam int CELL_WAIT = MAX_PLANES + 3;
	localparam int CW        = $clog2(CELL_WAIT + 1);
	localparam logic [63:0] TERM_CAP = (64'd1 << 47) - 64'd1;
	localparam logic [63:0] HI_CAP   = TERM_CAP >> (32 - FRAC_BITS);
	localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRAC_BITS;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_ROT  = 9'b000000010,
		S_LOC  = 9'b000000100,
		S_CELL = 9'b000001000,
		S_SC1  = 9'b000010000,
		S_SC2  = 9'b000100000,
		S_BL1  = 9'b001000000,
		S_BL2  = 9'b010000000,
		S_HOLD = 9'b100000000
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;

	// Configuration registers.
	logic [4:0]  plane_count_q;
	logic [16:0] k_weight_q;
	logic [31:0] inv_small_q, inv_big_q;
	logic        clump_q;
	logic        cfg_wr;
	reg_index_t  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_index_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q <= '0;
			k_weight_q <= '0;
			inv_small_q <= 32'd1 << FRAC_BITS;
			inv_big_q <= 32'd1 << FRAC_BITS;
			clump_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PLANE_COUNT: plane_count_q <= pwdata[4:0];
				REG_K_WEIGHT:    k_weight_q <= pwdata[16:0];
				REG_INV_SMALL:   inv_small_q <= pwdata;
				REG_INV_BIG:     inv_big_q <= pwdata;
				REG_CLUMP_MODE:  clump_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_PLANE_COUNT: prdata = {27'd0, plane_count_q};
			REG_K_WEIGHT:    prdata = {15'd0, k_weight_q};
			REG_INV_SMALL:   prdata = inv_small_q;
			REG_INV_BIG:     prdata = inv_big_q;
			REG_CLUMP_MODE:  prdata = {31'd0, clump_q};
			default:         prdata = '0;
		endcase
	end

	// Input side.
	logic in_acc, is_eval, is_plane, is_xform;
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc   = in_ch.valid & in_ch.ready;
	assign is_eval  = in_acc && (action_t'(in_ch.action) == ACT_EVAL);
	assign is_plane = in_acc && (action_t'(in_ch.action) == ACT_LOAD_PLANE);
	assign is_xform = in_acc && (action_t'(in_ch.action) == ACT_LOAD_XFORM);

	logic signed [31:0] rot_q [ROT_WORDS];
	logic signed [31:0] ctr_q [3];
	logic signed [31:0] pt_q [3];

	always_ff @(posedge clk) begin
		if (is_xform) begin
			if (int'(in_ch.slot_index) < ROT_WORDS)
				rot_q[in_ch.slot_index] <= in_ch.word_a;
			else if (int'(in_ch.slot_index) < XFORM_WORDS)
				ctr_q[2'(in_ch.slot_index - 4'(CENTRE_BASE))] <= in_ch.word_a;
		end
		if (is_eval) begin
			pt_q[0] <= in_ch.point_x;
			pt_q[1] <= in_ch.point_y;
			pt_q[2] <= in_ch.point_z;
		end
	end

	// Rotation products, then local coordinates (point minus centre in clump mode).
	logic signed [63:0] rp_s1 [ROT_WORDS];
	logic signed [31:0] loc_q [3];
	logic               sat_loc_q;
	logic signed [63:0] lv [3];
	logic [2:0]         lsat;
	logic signed [31:0] lclip [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < ROT_WORDS; k++)
			rp_s1[k] <= (64'(rot_q[k]) * 64'(pt_q[k % 3])) >>> FRAC_BITS;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (clump_q)
				lv[i] = 64'(pt_q[i]) - 64'(ctr_q[i]);
			else
				lv[i] = rp_s1[3*i] + rp_s1[3*i+1] + rp_s1[3*i+2];
			if (lv[i] > 64'sh7FFF_FFFF) begin
				lclip[i] = 32'sh7FFF_FFFF;
				lsat[i] = 1'b1;
			end else if (lv[i] < -64'sh8000_0000) begin
				lclip[i] = 32'sh8000_0000;
				lsat[i] = 1'b1;
			end else begin
				lclip[i] = lv[i][31:0];
				lsat[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOC) begin
			loc_q <= lclip;
			sat_loc_q <= |lsat;
		end
	end

	// Sphere term.
	logic [63:0] sq_s1 [3];
	logic [63:0] sph_s2;
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			sq_s1[i] <= 64'((64'(loc_q[i]) * 64'(loc_q[i])) >>> FRAC_BITS);
		sph_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
	end

	// Chain of plane cells.
	ppf_link_t link [MAX_PLANES+1];
	assign link[0] = '0;

	generate
		for (genvar g = 0; g < MAX_PLANES; g++) begin : g_cell
			ppf_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
				.clk      (clk),
				.load     (is_plane && (int'(in_ch.slot_index) == g)),
				.coef_a   (in_ch.word_a),
				.coef_b   (in_ch.word_b),
				.coef_c   (in_ch.word_c),
				.coef_d   (in_ch.word_d),
				.loc_x    (loc_q[0]),
				.loc_y    (loc_q[1]),
				.loc_z    (loc_q[2]),
				.active   (int'(plane_count_q) > g),
				.link_in  (link[g]),
				.link_out (link[g+1])
			);
		end
	endgenerate

	// Scaling by the reciprocal radii, split into two 32-bit halves.
	logic [63:0] ph_s1, pl_s1, sh_s1, sl_s1;
	logic        satc_s1;
	always_ff @(posedge clk) begin
		ph_s1 <= 64'(link[MAX_PLANES].sum[63:32]) * 64'(inv_small_q);
		pl_s1 <= 64'(link[MAX_PLANES].sum[31:0]) * 64'(inv_small_q);
		sh_s1 <= 64'(sph_s2[63:32]) * 64'(inv_big_q);
		sl_s1 <= 64'(sph_s2[31:0]) * 64'(inv_big_q);
		satc_s1 <= link[MAX_PLANES].sat;
	end

	logic [63:0] vp, vs, s1v, s2v;
	logic        sat_pc, sat_sc;
	always_comb begin
		vp = (ph_s1 << (32 - FRAC_BITS)) + (pl_s1 >> FRAC_BITS);
		vs = (sh_s1 << (32 - FRAC_BITS)) + (sl_s1 >> FRAC_BITS);
		sat_pc = (ph_s1 > HI_CAP) || (vp > TERM_CAP);
		sat_sc = (sh_s1 > HI_CAP) || (vs > TERM_CAP);
		s1v = sat_pc ? TERM_CAP : vp;
		s2v = sat_sc ? TERM_CAP : vs;
	end

	logic signed [48:0] g1_s2, g2_s2;
	logic               satp_s2, sats_s2;
	always_ff @(posedge clk) begin
		g1_s2 <= 49'($signed(s1v) - ONE_FX);
		g2_s2 <= 49'($signed(s2v) - ONE_FX);
		satp_s2 <= satc_s1 | sat_pc;
		sats_s2 <= sat_sc;
	end

	// Blend: each weight times the high and low parts of each term.
	logic [16:0] w1, w2;
	assign w2 = (k_weight_q > K_ONE) ? K_ONE : k_weight_q;
	assign w1 = K_ONE - w2;

	logic signed [42:0] p1h_s3, p2h_s3;
	logic [40:0]        p1l_s3, p2l_s3;
	logic               sat_s3;
	always_ff @(posedge clk) begin
		p1h_s3 <= 43'($signed({1'b0, w1})) * 43'($signed(g1_s2[48:24]));
		p2h_s3 <= 43'($signed({1'b0, w2})) * 43'($signed(g2_s2[48:24]));
		p1l_s3 <= 41'(w1) * 41'(g1_s2[23:0]);
		p2l_s3 <= 41'(w2) * 41'(g2_s2[23:0]);
		sat_s3 <= sat_loc_q | ((w1 != '0) & satp_s2) | ((w2 != '0) & sats_s2);
	end

	logic signed [67:0] acc;
	assign acc = ((68'(p1h_s3) + 68'(p2h_s3)) <<< 24)
		+ $signed(68'(p1l_s3)) + $signed(68'(p2l_s3));

	// Result register and sequencer.
	logic out_valid_q;
	logic out_take;
	logic in_blend;
	logic out_load;
	assign out_take = out_valid_q & out_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign in_blend = (state_q == S_BL2) || (state_q == S_HOLD);
	assign out_load = in_blend && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch.potential_value <= acc[63:16];
			out_ch.saturated <= sat_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_take)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (is_eval) state_q <= S_ROT;
				S_ROT:  state_q <= S_LOC;
				S_LOC: begin
					state_q <= S_CELL;
					cnt_q <= '0;
				end
				S_CELL: begin
					if (cnt_q == CW'(CELL_WAIT - 1))
						state_q <= S_SC1;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_SC1: state_q <= S_SC2;
				S_SC2: state_q <= S_BL1;
				S_BL1: state_q <= S_BL2;
				S_BL2, S_HOLD: begin
					if (out_load)
						state_q <= S_IDLE;
					else
						state_q <= S_HOLD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PPF_ASSERT_NXT(a_eval_starts, clk, arst_n, is_eval, state_q == S_ROT)
	`PPF_ASSERT_IMP(a_cnt_bound, clk, arst_n, state_q == S_CELL, cnt_q < CW'(CELL_WAIT))
	`PPF_ASSERT(a_out_from_blend, clk, arst_n, $rose(out_valid_q) |-> $past(in_blend))
endmodule
`default_nettype wire

[tb/tb_potential_particle_field_eval_unit.sv]
// Self-checking bench for the potential field evaluator: a directed table, then random phases
// under several register settings, checked vs typed values or this file's fixed-point model.
// Depends on ppf_pkg, ppf_in_if, ppf_out_if and potential_particle_field_eval_unit.
`default_nettype none
module tb_potential_particle_field_eval_unit;
	import ppf_pkg::*;

	typedef struct {
		action_t            act;
		logic [3:0]         slot;
		logic signed [31:0] a, b, c, d, x, y, z;
	} beat_t;

	typedef struct {
		logic [47:0] value;
		bit          sat;
	} field_t;

	typedef struct {
		beat_t       it;
		bit          known;
		logic [47:0] value;
		bit          sat;
	} row_t;

	localparam longint unsigned TERM_CAP = (64'd1 << 47) - 1;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam logic [31:0] S_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S_MIN = 32'h8000_0000;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	ppf_in_if in_if();
	ppf_out_if out_if();

	potential_particle_field_eval_unit u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_if), .out_ch(out_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow of the block's tables and registers.
	logic signed [31:0] pl_a[16], pl_b[16], pl_c[16], pl_d[16], rot[9], cen[3];
	logic [4:0]  cfg_count;
	logic [16:0] cfg_k;
	logic [31:0] cfg_inv_s, cfg_inv_b;
	bit          cfg_clump;

	field_t pending_fields[$];
	int errors = 0;
	int hold_len = 0;
	bit quiet_tx = 0, quiet_rx = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 2000000);
		$display("** potential_particle_field_eval_unit: FAILED **");
		$finish;
	end

	task automatic report(input string msg);
		errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	function automatic longint clip32(input longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint unsigned scale_q16(input longint unsigned a,
			input logic [31:0] b, inout bit sat);
		longint unsigned hi, lo, v;
		hi = (a >> 32) * longint'(b);
		lo = (a & 64'hffff_ffff) * longint'(b);
		if (hi > (TERM_CAP >> 16)) begin
			sat = 1;
			return TERM_CAP;
		end
		v = (hi << 16) + (lo >> 16);
		if (v > TERM_CAP) begin
			sat = 1;
			return TERM_CAP;
		end
		return v;
	endfunction

	// Potential value of one sample point under the current shadow state.
	function automatic field_t field_at(input beat_t it);
		longint pt[3], loc[3], v, t, g1, g2, acc;
		longint unsigned psum, sph, s1, s2;
		bit sat_loc, sat_p, sat_s;
		int n;
		longint w1, w2;
		field_t r;
		psum = 0;
		sph = 0;
		sat_loc = 0;
		sat_p = 0;
		sat_s = 0;
		pt[0] = it.x;
		pt[1] = it.y;
		pt[2] = it.z;
		for (int i = 0; i < 3; i++) begin
			v = 0;
			if (cfg_clump)
				v = pt[i] - longint'(cen[i]);
			else
				for (int j = 0; j < 3; j++)
					v += (longint'(rot[3 * i + j]) * pt[j]) >>> 16;
			loc[i] = clip32(v, sat_loc);
		end
		n = (cfg_count > 16) ? 16 : cfg_count;
		for (int i = 0; i < n; i++) begin
			t = ((longint'(pl_a[i]) * loc[0]) >>> 16) + ((longint'(pl_b[i]) * loc[1]) >>> 16)
				+ ((longint'(pl_c[i]) * loc[2]) >>> 16) - longint'(pl_d[i]);
			if (t > 0) begin
				if (t > 64'sd2147483647) begin
					t = 64'sd2147483647;
					sat_p = 1;
				end
				psum += (longint'(t) * t) >> 16;
			end
		end
		for (int i = 0; i < 3; i++)
			sph += longint'(loc[i] * loc[i]) >> 16;
		s1 = scale_q16(psum, cfg_inv_s, sat_p);
		s2 = scale_q16(sph, cfg_inv_b, sat_s);
		g1 = longint'(s1) - 65536;
		g2 = longint'(s2) - 65536;
		w2 = (cfg_k > K_ONE) ? 65536 : cfg_k;
		w1 = 65536 - w2;
		acc = w1 * g1 + w2 * g2;
		r.value = 48'(acc >>> 16);
		r.sat = sat_loc || (w1 != 0 && sat_p) || (w2 != 0 && sat_s);
		return r;
	endfunction

	// Applies an accepted beat to the shadow tables and queues its result, if any.
	task automatic absorb_beat(input beat_t it, input bit known, input field_t typed);
		field_t exp_f;
		case (it.act)
			ACT_LOAD_PLANE: begin
				pl_a[it.slot] = it.a;
				pl_b[it.slot] = it.b;
				pl_c[it.slot] = it.c;
				pl_d[it.slot] = it.d;
			end
			ACT_LOAD_XFORM: begin
				if (it.slot < ROT_WORDS)
					rot[it.slot] = it.a;
				else if (it.slot < XFORM_WORDS)
					cen[it.slot - CENTRE_BASE] = it.a;
			end
			ACT_EVAL: begin
				exp_f = known ? typed : field_at(it);
				pending_fields = {pending_fields, exp_f};
			end
			default: ;
		endcase
	endtask

	task automatic send_beat(input beat_t it, input bit known, input field_t typed);
		int gap;
		gap = quiet_tx ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_if.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid <= 1;
		in_if.action <= it.act;
		in_if.slot_index <= it.slot;
		in_if.word_a <= it.a;
		in_if.word_b <= it.b;
		in_if.word_c <= it.c;
		in_if.word_d <= it.d;
		in_if.point_x <= it.x;
		in_if.point_y <= it.y;
		in_if.point_z <= it.z;
		do @(posedge clk); while (!in_if.ready);
		absorb_beat(it, known, typed);
		if ($urandom_range(0, 150) == 0) quiet_tx = !quiet_tx;
	endtask

	task automatic send_checked(input beat_t it);
		field_t none;
		none = '{0, 0};
		send_beat(it, 0, none);
	endtask

	task automatic reg_write(input reg_index_t r, input logic [31:0] v);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (r)
			REG_PLANE_COUNT: cfg_count = v[4:0];
			REG_K_WEIGHT:    cfg_k = v[16:0];
			REG_INV_SMALL:   cfg_inv_s = v;
			REG_INV_BIG:     cfg_inv_b = v;
			REG_CLUMP_MODE:  cfg_clump = v[0];
			default: ;
		endcase
	endtask

	// Waits until every result has arrived, then lets a trailing load drain.
	task automatic drain();
		in_if.valid <= 0;
		wait (pending_fields.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] coef_word();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? S_MAX : S_MIN;
			default: return $urandom_range(0, 262143) - 131072;
		endcase
	endfunction

	function automatic logic [31:0] point_word();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? S_MAX : S_MIN;
			default: return $urandom_range(0, 2097151) - 1048576;
		endcase
	endfunction

	function automatic beat_t random_beat();
		beat_t it;
		int pick;
		pick = $urandom_range(0, 99);
		it.act = (pick < 60) ? ACT_EVAL : (pick < 78) ? ACT_LOAD_PLANE :
			(pick < 95) ? ACT_LOAD_XFORM : ACT_NONE;
		it.slot = $urandom_range(0, 15);
		it.a = coef_word();
		it.b = coef_word();
		it.c = coef_word();
		it.d = coef_word();
		it.x = point_word();
		it.y = point_word();
		it.z = point_word();
		// Rotation words mostly stay near unit scale so points rarely clip.
		if (it.act == ACT_LOAD_XFORM && it.slot < ROT_WORDS && $urandom_range(0, 3) != 0)
			it.a = $urandom_range(0, 131071) - 65536;
		return it;
	endfunction

	function automatic beat_t mk(input action_t act, input logic [3:0] slot,
			input logic [31:0] a, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		beat_t it;
		it = '{act, slot, a, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f, x, y, z};
		return it;
	endfunction

	// Result side: random stalls, plus a long hold-off when asked.
	initial begin : result_sink
		int stall;
		field_t exp_f;
		out_if.ready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				out_if.ready <= 0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			stall = quiet_rx ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				out_if.ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_if.ready <= 1;
			do @(posedge clk); while (!out_if.valid);
			if (pending_fields.size() == 0) begin
				report("result beat with nothing pending");
			end else begin
				exp_f = pending_fields.pop_front();
				if (out_if.potential_value !== exp_f.value)
					report($sformatf("potential_value %h, want %h",
						out_if.potential_value, exp_f.value));
				if (out_if.saturated !== exp_f.sat)
					report($sformatf("saturated %b, want %b", out_if.saturated, exp_f.sat));
			end
			if ($urandom_range(0, 150) == 0) quiet_rx = !quiet_rx;
		end
	end

	initial begin : stimulus
		row_t rows[$];
		beat_t it;
		field_t typed;
		logic [47:0] base;
		base = -48'sd65536;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		in_if.valid = 0;
		in_if.action = ACT_NONE;
		in_if.slot_index = '0;
		in_if.word_a = '0;
		in_if.word_b = '0;
		in_if.word_c = '0;
		in_if.word_d = '0;
		in_if.point_x = '0;
		in_if.point_y = '0;
		in_if.point_z = '0;
		cfg_count = 0;
		cfg_k = 0;
		cfg_inv_s = Q_ONE;
		cfg_inv_b = Q_ONE;
		cfg_clump = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Fill every table entry before any evaluate can read it.
		for (int i = 0; i < 16; i++) begin
			it = random_beat();
			it.act = ACT_LOAD_PLANE;
			it.slot = i;
			send_checked(it);
		end
		for (int i = 0; i < XFORM_WORDS; i++)
			send_checked(mk(ACT_LOAD_XFORM, i, (i == 0 || i == 4 || i == 8) ? Q_ONE : 0,
				0, 0, 0));

		// Reset registers: no planes, k of zero, so f is minus one; clipping only sets saturated.
		rows = '{
			'{mk(ACT_EVAL, 0, 0, 0, 0, 0), 1, base, 0},
			'{mk(ACT_EVAL, 0, 0, S_MAX, S_MAX, S_MAX), 1, base, 0},
			'{mk(ACT_EVAL, 0, 0, S_MIN, S_MIN, S_MIN), 1, base, 0},
			'{mk(ACT_NONE, 15, S_MAX, 1, 2, 3), 0, 0, 0},
			'{mk(ACT_LOAD_XFORM, 12, S_MAX, 0, 0, 0), 0, 0, 0},
			'{mk(ACT_LOAD_XFORM, 15, S_MIN, 0, 0, 0), 0, 0, 0},
			'{mk(ACT_EVAL, 0, 0, Q_ONE, S_MIN, S_MAX), 1, base, 0},
			'{mk(ACT_LOAD_XFORM, 0, S_MAX, 0, 0, 0), 0, 0, 0},
			'{mk(ACT_EVAL, 0, 0, S_MAX, 0, 0), 1, base, 1},
			'{mk(ACT_EVAL, 0, 0, S_MIN, 0, 0), 1, base, 1},
			'{mk(ACT_LOAD_XFORM, 0, Q_ONE, 0, 0, 0), 0, 0, 0},
			'{mk(ACT_LOAD_XFORM, 11, S_MIN, 0, 0, 0), 0, 0, 0},
			'{mk(ACT_LOAD_PLANE, 15, Q_ONE, 0, 0, 0), 0, 0, 0},
			'{mk(ACT_EVAL, 0, 0, 32'h0003_0000, 32'hfffe_0000, 32'h0000_8000), 0, 0, 0},
			'{mk(ACT_EVAL, 0, 0, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001), 0, 0, 0}
		};
		foreach (rows[i]) begin
			typed = '{rows[i].value, rows[i].sat};
			send_beat(rows[i].it, rows[i].known, typed);
		end
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: begin
					reg_write(REG_PLANE_COUNT, 16);
					reg_write(REG_K_WEIGHT, 0);
					reg_write(REG_INV_SMALL, Q_ONE);
					reg_write(REG_INV_BIG, Q_ONE);
					reg_write(REG_CLUMP_MODE, 0);
				end
				1: begin
					reg_write(REG_PLANE_COUNT, 31);
					reg_write(REG_K_WEIGHT, 32'h0001_ffff);
					reg_write(REG_INV_SMALL, 32'hffff_ffff);
					reg_write(REG_INV_BIG, 32'hffff_ffff);
					reg_write(REG_CLUMP_MODE, 1);
				end
				2: begin
					reg_write(REG_PLANE_COUNT, 0);
					reg_write(REG_K_WEIGHT, 65536);
					reg_write(REG_INV_SMALL, 0);
					reg_write(REG_INV_BIG, 0);
					reg_write(REG_CLUMP_MODE, 0);
				end
				default: begin
					reg_write(REG_PLANE_COUNT, $urandom_range(0, 31));
					reg_write(REG_K_WEIGHT, $urandom_range(0, 3) == 0 ?
						$urandom_range(0, 131071) : $urandom_range(0, 65536));
					reg_write(REG_INV_SMALL, $urandom_range(0, 1) ? $urandom :
						$urandom_range(0, 262144));
					reg_write(REG_INV_BIG, $urandom_range(0, 1) ? $urandom :
						$urandom_range(0, 262144));
					reg_write(REG_CLUMP_MODE, $urandom_range(0, 1));
				end
			endcase
			for (int n = 0; n < 190; n++) begin
				if (ph == 4 && n == 20) hold_len = 400;
				send_checked(random_beat());
			end
			drain();
		end

		repeat (60) @(posedge clk);
		if (pending_fields.size() != 0)
			report($sformatf("%0d results never arrived", pending_fields.size()));
		if (errors == 0)
			$display("** potential_particle_field_eval_unit: PASSED **");
		else
			$display("** potential_particle_field_eval_unit: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
